>>> rtl/hwpc_pkg.sv
// ----------------------------------------------------------------------------
// hwpc_pkg
// Shared widths, register indexes, reset values and pipeline constants of the
// hit window pair calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package hwpc_pkg;

  // Default number of stored hits on each side.
  localparam int HITS_PER_SIDE_DEF = 8;

  // Field widths.
  localparam int CHAN_W   = 8;
  localparam int TIME_W   = 32;
  localparam int ENERGY_W = 16;
  localparam int ENTRY_W  = TIME_W + ENERGY_W;
  localparam int RES_W    = 48;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;

  // Calibration operand: signed, wide enough for a sum or difference of two times.
  localparam int OPND_W = TIME_W + 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_CUT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_CUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_CAL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_AMP_CAL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_AMP_CAL  = 3'd6;

  // Register reset values.
  localparam logic [15:0]      CHANNEL_SELECT_RST = 16'h0100;
  localparam logic             PAIR_MODE_RST      = 1'b1;
  localparam logic [63:0]      TIME_CUT_RST       = 64'hFFFF_FFFF_0000_0000;
  localparam logic [31:0]      ENERGY_CUT_RST     = 32'hFFFF_0000;
  localparam logic [CFG_W-1:0] CAL_RST            = 64'h0001_0000_0000_0000;

  // Number of register stages in the calibration unit.
  localparam int CAL_STAGES = 4;
  localparam int CALC_CNT_W = $clog2(CAL_STAGES + 1);

  // Saturation bounds of a result.
  localparam logic signed [RES_W-1:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [RES_W-1:0] SAT_MIN = 48'sh8000_0000_0000;

endpackage

`default_nettype wire

>>> rtl/hit_window_pair_calibrator.sv
// ----------------------------------------------------------------------------
// hit_window_pair_calibrator
// Collects windowed digitizer hits of one event in a left and a right buffer
// and, at the end of the event, emits calibrated left-right results (left only in single mode).
//
// Usage: hit items enter on the hit channel (hit_valid / hit_stall), results
// leave on the result channel (result_valid / result_stall). Registers are
// written through write_enable / write_index / write_data; the user must write
// them only while the block is idle, which the block does not enforce. While
// an event is being collected the block takes one hit item per cycle and
// produces nothing. An item with event_end set closes the event: the hit
// channel then stalls while the results are produced. Each result passes
// through a memory read, the four-stage calibration pipeline and the output
// register. When the receiver stalls, the result is held and the block
// waits. After the last result of the event, or at once for an event with no
// results, the buffers are cleared and the hit channel opens again. Reset
// empties both buffers, clears the overflow flag and loads the register
// defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_window_pair_calibrator #(
  parameter int HITS_PER_SIDE = hwpc_pkg::HITS_PER_SIDE_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration port.
  input  wire logic                                 write_enable,
  input  wire logic [hwpc_pkg::CFG_IDX_W-1:0]       write_index,
  input  wire logic [hwpc_pkg::CFG_W-1:0]           write_data,
  // Hit channel.
  input  wire logic                                 hit_valid,
  output logic                                      hit_stall,
  input  wire logic [hwpc_pkg::CHAN_W-1:0]          hit_channel,
  input  wire logic [hwpc_pkg::TIME_W-1:0]          hit_time,
  input  wire logic [hwpc_pkg::ENERGY_W-1:0]        hit_energy,
  input  wire logic                                 hit_present,
  input  wire logic                                 event_end,
  // Result channel.
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic      [hwpc_pkg::TIME_W-1:0]          left_time,
  output logic      [hwpc_pkg::TIME_W-1:0]          right_time,
  output logic signed [hwpc_pkg::RES_W-1:0]         time_sum,
  output logic signed [hwpc_pkg::RES_W-1:0]         time_difference,
  output logic signed [hwpc_pkg::RES_W-1:0]         left_amplitude,
  output logic signed [hwpc_pkg::RES_W-1:0]         right_amplitude,
  output logic                                      hits_dropped,
  output logic                                      last_of_event
);
  import hwpc_pkg::*;

  localparam int CNT_W = $clog2(HITS_PER_SIDE + 1);
  localparam int IDX_W = (HITS_PER_SIDE > 1) ? $clog2(HITS_PER_SIDE) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HITS_PER_SIDE);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CALC = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  // Configuration registers.
  logic [15:0]      channel_select;
  logic             pair_mode;
  logic [63:0]      time_cut;
  logic [31:0]      energy_cut;
  logic [CFG_W-1:0] time_cal;
  logic [CFG_W-1:0] left_amp_cal;
  logic [CFG_W-1:0] right_amp_cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= CHANNEL_SELECT_RST;
      pair_mode      <= PAIR_MODE_RST;
      time_cut       <= TIME_CUT_RST;
      energy_cut     <= ENERGY_CUT_RST;
      time_cal       <= CAL_RST;
      left_amp_cal   <= CAL_RST;
      right_amp_cal  <= CAL_RST;
    end else if (write_enable) begin
      case (write_index)
        REG_CHANNEL_SELECT: channel_select <= write_data[15:0];
        REG_PAIR_MODE:      pair_mode      <= write_data[0];
        REG_TIME_CUT:       time_cut       <= write_data;
        REG_ENERGY_CUT:     energy_cut     <= write_data[31:0];
        REG_TIME_CAL:       time_cal       <= write_data;
        REG_LEFT_AMP_CAL:   left_amp_cal   <= write_data;
        REG_RIGHT_AMP_CAL:  right_amp_cal  <= write_data;
        default: ;
      endcase
    end
  end

  // Control state.
  state_t               state;
  logic [CNT_W-1:0]     left_count;
  logic [CNT_W-1:0]     right_count;
  logic                 overflow_seen;
  logic                 emit_pair;
  logic [IDX_W-1:0]     left_idx;
  logic [IDX_W-1:0]     right_idx;
  logic [CALC_CNT_W-1:0] calc_cnt;

  // Hit filtering and buffer fill.
  logic             hit_accept;
  logic             in_window;
  logic             left_match;
  logic             right_match;
  logic             left_wr;
  logic             right_wr;
  logic             drop;
  logic [CNT_W-1:0] left_count_next;
  logic [CNT_W-1:0] right_count_next;
  logic             overflow_next;
  logic             has_results;

  always_comb begin
    hit_accept  = hit_valid && !hit_stall;
    in_window   = (hit_time > time_cut[31:0]) && (hit_time < time_cut[63:32]) &&
                  (hit_energy > energy_cut[15:0]) && (hit_energy < energy_cut[31:16]);
    left_match  = hit_present && in_window && (hit_channel == channel_select[7:0]);
    right_match = hit_present && in_window && pair_mode &&
                  (hit_channel == channel_select[15:8]);
    left_wr     = hit_accept && left_match && (left_count < CNT_FULL);
    right_wr    = hit_accept && right_match && (right_count < CNT_FULL);
    drop        = hit_accept && ((left_match && (left_count == CNT_FULL)) ||
                                 (right_match && (right_count == CNT_FULL)));
    left_count_next  = left_count + CNT_W'(left_wr);
    right_count_next = right_count + CNT_W'(right_wr);
    overflow_next    = overflow_seen || drop;
    has_results = pair_mode ? ((left_count_next != '0) && (right_count_next != '0))
                            : (left_count_next != '0);
  end

  // Hit buffers.
  logic [ENTRY_W-1:0] left_rd;
  logic [ENTRY_W-1:0] right_rd;

  hwpc_hit_mem #(.DEPTH(HITS_PER_SIDE)) u_left_mem (
    .clk     (clk),
    .wr_en   (left_wr),
    .wr_addr (left_count[IDX_W-1:0]),
    .wr_data ({hit_time, hit_energy}),
    .rd_addr (left_idx),
    .rd_data (left_rd)
  );

  hwpc_hit_mem #(.DEPTH(HITS_PER_SIDE)) u_right_mem (
    .clk     (clk),
    .wr_en   (right_wr),
    .wr_addr (right_count[IDX_W-1:0]),
    .wr_data ({hit_time, hit_energy}),
    .rd_addr (right_idx),
    .rd_data (right_rd)
  );

  // Operands of the calibration units; the right side reads as zero in
  // single mode.
  logic [TIME_W-1:0]          tl;
  logic [TIME_W-1:0]          tr;
  logic [ENERGY_W-1:0]        el;
  logic [ENERGY_W-1:0]        er;
  logic signed [OPND_W-1:0]   sum_opnd;
  logic signed [OPND_W-1:0]   diff_opnd;
  logic signed [OPND_W-1:0]   el_opnd;
  logic signed [OPND_W-1:0]   er_opnd;

  always_comb begin
    tl = left_rd[ENTRY_W-1:ENERGY_W];
    el = left_rd[ENERGY_W-1:0];
    tr = emit_pair ? right_rd[ENTRY_W-1:ENERGY_W] : '0;
    er = emit_pair ? right_rd[ENERGY_W-1:0] : '0;
    sum_opnd  = $signed(OPND_W'(tl)) + $signed(OPND_W'(tr));
    diff_opnd = $signed(OPND_W'(tl)) - $signed(OPND_W'(tr));
    el_opnd   = $signed(OPND_W'(el));
    er_opnd   = $signed(OPND_W'(er));
  end

  logic signed [RES_W-1:0] sum_cal;
  logic signed [RES_W-1:0] diff_cal;
  logic signed [RES_W-1:0] left_cal;
  logic signed [RES_W-1:0] right_cal;

  hwpc_calib u_sum_cal   (.clk(clk), .operand(sum_opnd),  .cal(time_cal),      .result(sum_cal));
  hwpc_calib u_diff_cal  (.clk(clk), .operand(diff_opnd), .cal(time_cal),      .result(diff_cal));
  hwpc_calib u_left_cal  (.clk(clk), .operand(el_opnd),   .cal(left_amp_cal),  .result(left_cal));
  hwpc_calib u_right_cal (.clk(clk), .operand(er_opnd),   .cal(right_amp_cal), .result(right_cal));

  // Position within the left-major walk over the pairs.
  logic left_at_end;
  logic right_at_end;
  logic calc_done;

  always_comb begin
    left_at_end  = (CNT_W'(left_idx) + CNT_W'(1)) == left_count;
    right_at_end = !emit_pair || ((CNT_W'(right_idx) + CNT_W'(1)) == right_count);
    calc_done    = (calc_cnt == CALC_CNT_W'(CAL_STAGES));
  end

  // Sequencer: collect, then read, calibrate and send each result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      left_count    <= '0;
      right_count   <= '0;
      overflow_seen <= 1'b0;
      emit_pair     <= 1'b0;
      left_idx      <= '0;
      right_idx     <= '0;
      calc_cnt      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (hit_accept) begin
            if (event_end && has_results) begin
              left_count    <= left_count_next;
              right_count   <= right_count_next;
              overflow_seen <= overflow_next;
              emit_pair     <= pair_mode;
              left_idx      <= '0;
              right_idx     <= '0;
              state         <= ST_READ;
            end else if (event_end) begin
              left_count    <= '0;
              right_count   <= '0;
              overflow_seen <= 1'b0;
            end else begin
              left_count    <= left_count_next;
              right_count   <= right_count_next;
              overflow_seen <= overflow_next;
            end
          end
        end
        ST_READ: begin
          calc_cnt <= '0;
          state    <= ST_CALC;
        end
        ST_CALC: begin
          calc_cnt <= calc_cnt + CALC_CNT_W'(1);
          if (calc_done) begin
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (!result_stall) begin
            if (last_of_event) begin
              left_count    <= '0;
              right_count   <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              if (!right_at_end) begin
                right_idx <= right_idx + IDX_W'(1);
              end else begin
                right_idx <= '0;
                left_idx  <= left_idx + IDX_W'(1);
              end
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register, loaded when the calibration pipeline has drained.
  always_ff @(posedge clk) begin
    if ((state == ST_CALC) && calc_done) begin
      left_time       <= tl;
      right_time      <= tr;
      time_sum        <= sum_cal;
      time_difference <= diff_cal;
      left_amplitude  <= left_cal;
      right_amplitude <= right_cal;
      hits_dropped    <= overflow_seen;
      last_of_event   <= left_at_end && right_at_end;
    end
  end

  // Handshake outputs.
  always_comb begin
    hit_stall    = (state != ST_IDLE);
    result_valid = (state == ST_SEND);
  end

endmodule

`default_nettype wire

>>> rtl/hwpc_hit_mem.sv
// ----------------------------------------------------------------------------
// hwpc_hit_mem
// Hit buffer memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module hwpc_hit_mem #(
  parameter int DEPTH = hwpc_pkg::HITS_PER_SIDE_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [hwpc_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [hwpc_pkg::ENTRY_W-1:0] rd_data
);
  import hwpc_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/hwpc_calib.sv
// ----------------------------------------------------------------------------
// hwpc_calib
// Calibration pipeline: operand times Q16.16 gain plus Q16.16 offset, with
// the product clamped and the result saturated to 48 bits. Four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hwpc_calib (
  input  wire logic                                clk,
  input  wire logic signed [hwpc_pkg::OPND_W-1:0]  operand,
  input  wire logic        [hwpc_pkg::CFG_W-1:0]   cal,
  output logic signed      [hwpc_pkg::RES_W-1:0]   result
);
  import hwpc_pkg::*;

  localparam int MAG_W = OPND_W - 1;   // magnitude of the operand
  localparam int LO_W  = 17;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int PROD_W = MAG_W + 32;
  localparam int CLAMP_W = RES_W + 1;
  localparam logic [CLAMP_W-1:0] MAG_LIMIT = {1'b1, {RES_W{1'b0}}};

  // Stage one: magnitudes and sign.
  logic [MAG_W-1:0]   s1_ua;
  logic [31:0]        s1_ug;
  logic               s1_neg;
  logic signed [31:0] s1_off;
  logic [OPND_W-1:0]  a_abs;
  logic [31:0]        g_abs;

  always_comb begin
    a_abs = operand[OPND_W-1] ? OPND_W'(-operand) : OPND_W'(operand);
    g_abs = cal[63] ? 32'(-cal[63:32]) : cal[63:32];
  end

  always_ff @(posedge clk) begin
    s1_ua  <= a_abs[MAG_W-1:0];
    s1_ug  <= g_abs;
    s1_neg <= operand[OPND_W-1] ^ cal[63];
    s1_off <= $signed(cal[31:0]);
  end

  // Stage two: two partial products.
  logic [LO_W+31:0]   s2_plo;
  logic [HI_W+31:0]   s2_phi;
  logic               s2_neg;
  logic signed [31:0] s2_off;

  always_ff @(posedge clk) begin
    s2_plo <= s1_ua[LO_W-1:0] * s1_ug;
    s2_phi <= s1_ua[MAG_W-1:LO_W] * s1_ug;
    s2_neg <= s1_neg;
    s2_off <= s1_off;
  end

  // Stage three: combine the partial products and clamp the magnitude.
  logic [PROD_W-1:0]  mag;
  logic [CLAMP_W-1:0] s3_mag;
  logic               s3_neg;
  logic signed [31:0] s3_off;

  always_comb begin
    mag = PROD_W'({s2_phi, {LO_W{1'b0}}}) + PROD_W'(s2_plo);
  end

  always_ff @(posedge clk) begin
    s3_mag <= (mag > PROD_W'(MAG_LIMIT)) ? MAG_LIMIT : mag[CLAMP_W-1:0];
    s3_neg <= s2_neg;
    s3_off <= s2_off;
  end

  // Stage four: apply the sign, add the offset and saturate.
  logic signed [CLAMP_W+1:0] signed_mag;
  logic signed [CLAMP_W+1:0] total;

  always_comb begin
    signed_mag = $signed({2'b00, s3_mag});
    if (s3_neg) begin
      signed_mag = -signed_mag;
    end
    total = signed_mag + (CLAMP_W + 2)'(s3_off);
  end

  always_ff @(posedge clk) begin
    if (total > (CLAMP_W + 2)'(SAT_MAX)) begin
      result <= SAT_MAX;
    end else if (total < (CLAMP_W + 2)'(SAT_MIN)) begin
      result <= SAT_MIN;
    end else begin
      result <= total[RES_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> verif/hit_window_pair_calibrator_test.sv
// ----------------------------------------------------------------------------
// hit_window_pair_calibrator_test
// Self-checking testbench of the hit window pair calibrator. Hit items are
// driven over the valid/stall channel with random gaps and results are taken
// with random receiver stalls. A scoreboard class keeps its own copy of the
// registers and hit buffers, predicts every calibrated result when an event
// closes, and compares each result with the prediction in order. A short directed
// sequence covers window edges, buffer overflow, saturation, single mode, an
// empty event and a mode change inside an event; random register settings and
// random events follow.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_window_pair_calibrator_test;
  import hwpc_pkg::*;

  localparam int DEPTH            = HITS_PER_SIDE_DEF;
  localparam int SETTLE_CYCLES    = 24;
  localparam int RANDOM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE  = 42;
  localparam int MAX_REPORTS      = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [79:0] PRODUCT_CLAMP = 80'sh1_0000_0000_0000;

  // One register setting of the block.
  typedef struct packed {
    logic [15:0] chan_sel;
    logic        pair_on;
    logic [63:0] time_cut;
    logic [31:0] energy_cut;
    logic [63:0] time_cal;
    logic [63:0] left_cal;
    logic [63:0] right_cal;
  } setup_t;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [TIME_W-1:0] left_time;
    logic [TIME_W-1:0] right_time;
    logic [RES_W-1:0]  time_sum;
    logic [RES_W-1:0]  time_difference;
    logic [RES_W-1:0]  left_amplitude;
    logic [RES_W-1:0]  right_amplitude;
    logic              hits_dropped;
    logic              last_of_event;
  } pair_result_t;

  // Scoreboard: mirrors registers and hit buffers and predicts the pairs.
  class pair_calibration_model;
    logic [15:0]         chan_sel;
    logic                pair_on;
    logic [63:0]         time_window;
    logic [31:0]         energy_window;
    logic [63:0]         time_scale;
    logic [63:0]         left_scale;
    logic [63:0]         right_scale;
    logic [TIME_W-1:0]   left_time_buf[DEPTH];
    logic [ENERGY_W-1:0] left_energy_buf[DEPTH];
    logic [TIME_W-1:0]   right_time_buf[DEPTH];
    logic [ENERGY_W-1:0] right_energy_buf[DEPTH];
    int                  left_fill;
    int                  right_fill;
    bit                  overflowed;
    pair_result_t        awaited_pairs[$];
    int                  mismatches;
    int                  results_seen;
    int                  events_closed;

    function new();
      chan_sel      = CHANNEL_SELECT_RST;
      pair_on       = PAIR_MODE_RST;
      time_window   = TIME_CUT_RST;
      energy_window = ENERGY_CUT_RST;
      time_scale    = CAL_RST;
      left_scale    = CAL_RST;
      right_scale   = CAL_RST;
      left_fill     = 0;
      right_fill    = 0;
      overflowed    = 0;
      mismatches    = 0;
      results_seen  = 0;
      events_closed = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CHANNEL_SELECT: chan_sel = data[15:0];
        REG_PAIR_MODE:      pair_on = data[0];
        REG_TIME_CUT:       time_window = data;
        REG_ENERGY_CUT:     energy_window = data[31:0];
        REG_TIME_CAL:       time_scale = data;
        REG_LEFT_AMP_CAL:   left_scale = data;
        REG_RIGHT_AMP_CAL:  right_scale = data;
        default: ;
      endcase
    endfunction

    // Integer times signed Q16.16 gain, product clamped to 2^48 in magnitude,
    // plus offset, then saturated to the signed 48-bit range.
    function logic [RES_W-1:0] scale(logic signed [35:0] operand, logic [63:0] cal);
      logic signed [31:0] gain;
      logic signed [31:0] offset;
      logic signed [79:0] acc;
      gain = cal[63:32];
      offset = cal[31:0];
      acc = operand * gain;
      if (acc > PRODUCT_CLAMP) acc = PRODUCT_CLAMP;
      else if (acc < -PRODUCT_CLAMP) acc = -PRODUCT_CLAMP;
      acc = acc + offset;
      if (acc > SAT_MAX) acc = SAT_MAX;
      else if (acc < SAT_MIN) acc = SAT_MIN;
      return acc[RES_W-1:0];
    endfunction

    function void queue_pair(logic [TIME_W-1:0] lt, logic [ENERGY_W-1:0] le,
                             logic [TIME_W-1:0] rt, logic [ENERGY_W-1:0] re, bit last);
      pair_result_t r;
      logic signed [35:0] l_op;
      logic signed [35:0] r_op;
      l_op = {4'b0, lt};
      r_op = {4'b0, rt};
      r.left_time       = lt;
      r.right_time      = rt;
      r.time_sum        = scale(l_op + r_op, time_scale);
      r.time_difference = scale(l_op - r_op, time_scale);
      r.left_amplitude  = scale({20'b0, le}, left_scale);
      r.right_amplitude = scale({20'b0, re}, right_scale);
      r.hits_dropped    = overflowed;
      r.last_of_event   = last;
      awaited_pairs.insert(awaited_pairs.size(), r);
    endfunction

    // Called for every accepted hit item.
    function void file_hit(logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] t,
                           logic [ENERGY_W-1:0] e, logic present, logic closing);
      if (present && t > time_window[31:0] && t < time_window[63:32] &&
          e > energy_window[15:0] && e < energy_window[31:16]) begin
        if (ch == chan_sel[7:0]) begin
          if (left_fill == DEPTH) begin
            overflowed = 1;
          end else begin
            left_time_buf[left_fill] = t;
            left_energy_buf[left_fill] = e;
            left_fill++;
          end
        end
        if (pair_on && ch == chan_sel[15:8]) begin
          if (right_fill == DEPTH) begin
            overflowed = 1;
          end else begin
            right_time_buf[right_fill] = t;
            right_energy_buf[right_fill] = e;
            right_fill++;
          end
        end
      end
      if (closing) begin
        if (pair_on) begin
          if (left_fill > 0 && right_fill > 0) begin
            for (int i = 0; i < left_fill; i++)
              for (int j = 0; j < right_fill; j++)
                queue_pair(left_time_buf[i], left_energy_buf[i], right_time_buf[j],
                           right_energy_buf[j], i == left_fill - 1 && j == right_fill - 1);
          end
        end else begin
          for (int i = 0; i < left_fill; i++)
            queue_pair(left_time_buf[i], left_energy_buf[i], '0, '0, i == left_fill - 1);
        end
        left_fill = 0;
        right_fill = 0;
        overflowed = 0;
        events_closed++;
      end
    endfunction

    function string show(pair_result_t r);
      return $sformatf("lt=%h rt=%h sum=%h diff=%h lamp=%h ramp=%h drop=%b last=%b",
                       r.left_time, r.right_time, r.time_sum, r.time_difference,
                       r.left_amplitude, r.right_amplitude, r.hits_dropped, r.last_of_event);
    endfunction

    // Called for every accepted result item.
    function void match_result(pair_result_t got);
      pair_result_t want;
      if (awaited_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result with none pending: %s", show(got));
        return;
      end
      want = awaited_pairs.pop_front();
      results_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: result %0d differs at %0t", results_seen, $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  // Block signals; every input holds a known value from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]  write_index = '0;
  logic [CFG_W-1:0]      write_data = '0;
  logic                  hit_valid = 1'b0;
  logic                  hit_stall;
  logic [CHAN_W-1:0]     hit_channel = '0;
  logic [TIME_W-1:0]     hit_time = '0;
  logic [ENERGY_W-1:0]   hit_energy = '0;
  logic                  hit_present = 1'b0;
  logic                  event_end = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [TIME_W-1:0]     left_time;
  logic [TIME_W-1:0]     right_time;
  logic signed [RES_W-1:0] time_sum;
  logic signed [RES_W-1:0] time_difference;
  logic signed [RES_W-1:0] left_amplitude;
  logic signed [RES_W-1:0] right_amplitude;
  logic                  hits_dropped;
  logic                  last_of_event;

  pair_calibration_model model;
  pair_result_t          observed;
  bit                    steady = 1'b0;
  int                    items_sent = 0;
  int                    settings_applied = 0;

  hit_window_pair_calibrator DUT (
    .clk             (clk),
    .rst             (rst),
    .write_enable    (write_enable),
    .write_index     (write_index),
    .write_data      (write_data),
    .hit_valid       (hit_valid),
    .hit_stall       (hit_stall),
    .hit_channel     (hit_channel),
    .hit_time        (hit_time),
    .hit_energy      (hit_energy),
    .hit_present     (hit_present),
    .event_end       (event_end),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .left_time       (left_time),
    .right_time      (right_time),
    .time_sum        (time_sum),
    .time_difference (time_difference),
    .left_amplitude  (left_amplitude),
    .right_amplitude (right_amplitude),
    .hits_dropped    (hits_dropped),
    .last_of_event   (last_of_event)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign observed = {left_time, right_time, time_sum, time_difference, left_amplitude,
                     right_amplitude, hits_dropped, last_of_event};

  // Every accepted result item goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      model.match_result(observed);
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stalls in random bursts.
  initial begin : result_side
    int stall_len;
    forever begin
      repeat ($urandom_range(1, 8)) @(negedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        result_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Time inside the window most of the time, on its edges or anywhere otherwise.
  function automatic logic [TIME_W-1:0] pick_time(logic [63:0] cut);
    logic [31:0] lo;
    logic [31:0] hi;
    int r;
    lo = cut[31:0];
    hi = cut[63:32];
    r = $urandom_range(0, 99);
    if (r < 6) return lo;
    if (r < 12) return hi;
    if (r < 20) return $urandom;
    if ({1'b0, hi} > {1'b0, lo} + 33'd1) return lo + 32'd1 + ($urandom % (hi - lo - 32'd1));
    return $urandom;
  endfunction

  function automatic logic [ENERGY_W-1:0] pick_energy(logic [31:0] cut);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [31:0] span;
    int r;
    lo = cut[15:0];
    hi = cut[31:16];
    r = $urandom_range(0, 99);
    if (r < 6) return lo;
    if (r < 12) return hi;
    if (r < 20) return 16'($urandom);
    if ({1'b0, hi} > {1'b0, lo} + 17'd1) begin
      span = {16'b0, hi - lo - 16'd1};
      return lo + 16'd1 + 16'($urandom % span);
    end
    return 16'($urandom);
  endfunction

  // Gain and offset, with the signed extremes of both and a zero gain among the choices.
  function automatic logic [63:0] pick_cal();
    logic [31:0] gain;
    logic [31:0] offset;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) gain = 32'h7FFF_FFFF;
    else if (r == 1) gain = 32'h8000_0000;
    else if (r == 2) gain = 32'h0;
    else if (r == 3) gain = $urandom;
    else gain = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    r = $urandom_range(0, 9);
    if (r == 0) offset = 32'h7FFF_FFFF;
    else if (r == 1) offset = 32'h8000_0000;
    else if (r == 2) offset = $urandom;
    else offset = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    return {gain, offset};
  endfunction

  function automatic setup_t random_setup();
    setup_t s;
    logic [31:0] lo;
    logic [15:0] elo;
    int r;
    s.chan_sel[7:0] = 8'($urandom);
    if ($urandom_range(0, 3) == 0) s.chan_sel[15:8] = s.chan_sel[7:0];
    else s.chan_sel[15:8] = 8'($urandom);
    s.pair_on = ($urandom_range(0, 2) != 0);
    r = $urandom_range(0, 9);
    if (r == 0) begin
      s.time_cut = TIME_CUT_RST;
    end else if (r == 1) begin
      s.time_cut = {$urandom, $urandom};
    end else begin
      lo = $urandom_range(0, 32'h7FFF_FFFF);
      s.time_cut = {lo + 32'd2 + 32'($urandom_range(0, 32'h7FFF_FFFC)), lo};
    end
    r = $urandom_range(0, 9);
    if (r == 0) begin
      s.energy_cut = ENERGY_CUT_RST;
    end else if (r == 1) begin
      s.energy_cut = $urandom;
    end else begin
      elo = 16'($urandom_range(0, 16'h7FFF));
      s.energy_cut = {elo + 16'd2 + 16'($urandom_range(0, 16'h7FFC)), elo};
    end
    s.time_cal = pick_cal();
    s.left_cal = pick_cal();
    s.right_cal = pick_cal();
    return s;
  endfunction

  // Register write; entered and left at a falling edge with the enable high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(negedge clk);
    model.set_reg(idx, data);
  endtask

  // Writes every register; unused upper data bits carry noise.
  task automatic apply_setup(input setup_t s);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    write_reg(REG_CHANNEL_SELECT, {noise[63:16], s.chan_sel});
    write_reg(REG_PAIR_MODE, {noise[63:1], s.pair_on});
    write_reg(REG_TIME_CUT, s.time_cut);
    write_reg(REG_ENERGY_CUT, {noise[63:32], s.energy_cut});
    write_reg(REG_TIME_CAL, s.time_cal);
    write_reg(REG_LEFT_AMP_CAL, s.left_cal);
    write_reg(REG_RIGHT_AMP_CAL, s.right_cal);
    write_reg(REG_UNUSED, noise);
    write_enable <= 1'b0;
    settings_applied++;
  endtask

  // Sends one hit item; returns at the falling edge after it was taken.
  task automatic send_item(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] t,
                           input logic [ENERGY_W-1:0] e, input logic present,
                           input logic closing);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      hit_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    hit_valid <= 1'b1;
    hit_channel <= ch;
    hit_time <= t;
    hit_energy <= e;
    hit_present <= present;
    event_end <= closing;
    @(posedge clk);
    while (hit_stall) @(posedge clk);
    model.file_hit(ch, t, e, present, closing);
    items_sent++;
    @(negedge clk);
  endtask

  // Waits until every predicted result has come and the block has settled.
  task automatic hold_off();
    hit_valid <= 1'b0;
    while (model.awaited_pairs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One random event: hits mostly on the selected channels, some noise and
  // markers, closed by its last hit or by a separate marker.
  task automatic random_event(input setup_t s, inout int useful);
    int nhits;
    int r;
    int kind;
    logic [CHAN_W-1:0] ch;
    logic present;
    bit tail_marker;
    r = $urandom_range(0, 99);
    if (r < 12) nhits = 0;
    else if (r < 85) nhits = $urandom_range(1, 6);
    else nhits = $urandom_range(7, 12);
    tail_marker = (nhits == 0) || ($urandom_range(0, 1) == 0);
    for (int i = 0; i < nhits; i++) begin
      kind = $urandom_range(0, 99);
      present = (kind < 92);
      if (kind < 42) ch = s.chan_sel[7:0];
      else if (kind < 84) ch = s.chan_sel[15:8];
      else ch = 8'($urandom);
      if (kind < 84) useful++;
      send_item(ch, pick_time(s.time_cut), pick_energy(s.energy_cut), present,
                !tail_marker && i == nhits - 1);
    end
    if (tail_marker) send_item(8'($urandom), $urandom, 16'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    setup_t s;
    int useful;
    model = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: left channel 0, right channel 1, widest windows, unit gain.
    send_item(8'd0, 32'd1, 16'd1, 1'b1, 1'b0);
    send_item(8'd1, 32'hFFFF_FFFE, 16'hFFFE, 1'b1, 1'b0);
    send_item(8'd0, 32'd0, 16'd5, 1'b1, 1'b0);
    send_item(8'd0, 32'hFFFF_FFFF, 16'd5, 1'b1, 1'b0);
    send_item(8'd0, 32'd5, 16'd0, 1'b1, 1'b0);
    send_item(8'd1, 32'd5, 16'hFFFF, 1'b1, 1'b0);
    send_item(8'd0, 32'd77, 16'd77, 1'b0, 1'b0);
    send_item(8'd2, 32'd100, 16'd100, 1'b1, 1'b0);
    send_item(8'd1, 32'd7, 16'd9, 1'b1, 1'b1);
    // An event with no hits gives nothing.
    send_item(8'd0, 32'd3, 16'd3, 1'b0, 1'b1);
    hold_off();

    // Same channel on both sides, overflow of both buffers, saturating scales.
    s.chan_sel   = 16'h3333;
    s.pair_on    = 1'b1;
    s.time_cut   = TIME_CUT_RST;
    s.energy_cut = ENERGY_CUT_RST;
    s.time_cal   = 64'h7FFF_FFFF_7FFF_FFFF;
    s.left_cal   = 64'h8000_0000_8000_0000;
    s.right_cal  = 64'h0000_0000_8000_0000;
    apply_setup(s);
    for (int i = 0; i < 10; i++)
      send_item(8'h33, 32'd1 + ($urandom % 32'hFFFF_FFFD), 16'd1 + 16'($urandom % 16'hFFFD),
                1'b1, i == 9);
    hold_off();

    // Single mode: right channel hits are not kept.
    s.chan_sel  = 16'h0504;
    s.pair_on   = 1'b0;
    s.time_cal  = 64'h0001_0000_FFFF_0000;
    s.left_cal  = 64'h0002_0000_0000_8000;
    s.right_cal = 64'h0000_0000_0003_0000;
    apply_setup(s);
    send_item(8'd4, $urandom, 16'd300, 1'b1, 1'b0);
    send_item(8'd5, 32'd1000, 16'd400, 1'b1, 1'b0);
    send_item(8'd4, 32'd2000, 16'd500, 1'b1, 1'b1);
    send_item(8'd4, 32'd3000, 16'd600, 1'b1, 1'b0);
    hold_off();

    // Switch to pair mode with one left hit already held.
    write_reg(REG_PAIR_MODE, 64'd1);
    write_enable <= 1'b0;
    send_item(8'd5, 32'd3500, 16'd700, 1'b1, 1'b0);
    send_item(8'd4, 32'd4000, 16'd800, 1'b1, 1'b1);
    hold_off();

    // Random settings, each with a run of random events.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      s = random_setup();
      if (k == 0) s.chan_sel = 16'hFFFF;
      if (k == 3) s.time_cut = '0;
      if (k == 5) s.chan_sel = 16'h0000;
      steady = ($urandom_range(0, 3) == 0);
      apply_setup(s);
      useful = 0;
      while (useful < ITEMS_PER_PHASE) random_event(s, useful);
      hold_off();
    end

    $display("Sent %0d hit items in %0d events under %0d register settings.",
             items_sent, model.events_closed, settings_applied + 1);
    $display("Checked %0d results, %0d mismatches, %0d still pending.",
             model.results_seen, model.mismatches, model.awaited_pairs.size());
    if (model.mismatches == 0 && model.awaited_pairs.size() == 0) begin
      $display("hit_window_pair_calibrator_test: PASS");
    end else begin
      $display("hit_window_pair_calibrator_test: FAIL");
    end
    $finish;
  end

  // Hard stop for a hung handshake.
  initial begin
    #60000000;
    $display("Timeout with %0d results pending.", model.awaited_pairs.size());
    $display("hit_window_pair_calibrator_test: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
